[rtl/frame_deframer_sum16_macros.svh]
// assertion helpers shared by the deframer rtl
// both macros expect clk_i and rst_ni in scope
`ifndef FRAME_DEFRAMER_SUM16_MACROS_SVH
`define FRAME_DEFRAMER_SUM16_MACROS_SVH

// same-cycle implication
`define FDS16_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fds16 check failed");

// next-cycle implication
`define FDS16_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fds16 check failed");

`endif

[rtl/fds16_pkg.sv]
// ----------------------------------------------------------------------------
// fds16_pkg
// Shared constants and types of the byte-serial frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package fds16_pkg;

  localparam int unsigned MaxPayload = 60;
  localparam int unsigned IdxW       = $clog2(MaxPayload);

  localparam logic [7:0] HEAD_BYTE       = 8'hDF;
  localparam logic [7:0] TAIL_BYTE       = 8'hFD;
  localparam logic [7:0] OWN_ADDR_RESET  = 8'h97;
  localparam logic [7:0] PEER_ADDR_RESET = 8'h01;

  typedef enum logic [0:0] {
    REG_OWN_ADDR  = 1'b0,
    REG_PEER_ADDR = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HEAD = 2'd1,
    PH_BODY = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    CTL_PARSE = 2'd0,
    CTL_RD    = 2'd1,
    CTL_LD    = 2'd2
  } ctl_state_e;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    logic [7:0]      data;
  } store_wr_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
  } store_rd_t;

endpackage

`default_nettype wire

[rtl/fds16_if.sv]
// ----------------------------------------------------------------------------
// fds16 channel interfaces
// Valid/ready channels for received bytes and for deframed payload words.
// ----------------------------------------------------------------------------
`default_nettype none

interface fds16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface fds16_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_class;
  logic [7:0] frame_command;
  logic [5:0] payload_length;
  logic [5:0] byte_position;
  logic [7:0] payload_byte;
  logic       has_payload;
  logic       last;

  modport source (
    output valid, output frame_class, output frame_command, output payload_length,
    output byte_position, output payload_byte, output has_payload, output last,
    input ready
  );
  modport sink (
    input valid, input frame_class, input frame_command, input payload_length,
    input byte_position, input payload_byte, input has_payload, input last,
    output ready
  );
endinterface

`default_nettype wire

[rtl/fds16_store.sv]
// ----------------------------------------------------------------------------
// fds16_store
// Payload buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fds16_store import fds16_pkg::*; (
  input  wire logic       clk_i,
  input  wire store_wr_t  wr_i,
  input  wire store_rd_t  rd_i,
  output logic [7:0]      rd_data_o
);

  logic [7:0] mem_q [MaxPayload];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_data_o <= mem_q[rd_i.addr];
    end
  end

endmodule

`default_nettype wire

[rtl/frame_deframer_sum16.sv]
// ----------------------------------------------------------------------------
// frame_deframer_sum16
// Receives bytes, checks head, addresses, length, tail and 16-bit sum, and
// emits the payload of each good frame.
// ----------------------------------------------------------------------------
// Received bytes are taken one per cycle while the parser runs and the output
// register is free; payload bytes go into a 60-entry buffer as they arrive.
// When the last checksum byte of a good frame comes in, the buffer is read
// back and each payload byte leaves as one word, first a buffer read, then an
// output register load that waits while the sink holds ready low; no bytes
// are taken during that read-back. A frame of length zero gives one word
// straight from the parser. Bad frames produce nothing.
`default_nettype none

module frame_deframer_sum16 import fds16_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire cfg_reg_e  cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  fds16_in_if.sink       rx_i,
  fds16_out_if.source    frame_o
);

`include "frame_deframer_sum16_macros.svh"

  logic [7:0] own_addr_q, peer_addr_q;

  ctl_state_e ctl_q, ctl_d;
  phase_e     phase_q, phase_d;
  logic [6:0] cnt_q, cnt_d;
  logic [7:0] class_q, class_d;
  logic [7:0] cmd_q, cmd_d;
  logic [5:0] len_q, len_d;
  logic [15:0] sum_q, sum_d;
  logic       tok_q, tok_d;
  logic [7:0] sum_lo_q, sum_lo_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_class_q, out_class_d;
  logic [7:0] out_cmd_q, out_cmd_d;
  logic [5:0] out_len_q, out_len_d;
  logic [5:0] out_pos_q, out_pos_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_has_q, out_has_d;
  logic       out_last_q, out_last_d;

  logic       out_free, out_load, in_ready, in_acc;
  logic [7:0] b;
  logic [6:0] body_off;
  logic [15:0] sum_add;
  logic [7:0] rd_data;
  store_wr_t  st_wr;
  store_rd_t  st_rd;

  assign out_free = !out_valid_q || frame_o.ready;
  assign in_ready = (ctl_q == CTL_PARSE) && out_free;
  assign in_acc   = rx_i.valid && in_ready;
  assign b        = rx_i.rx_byte;
  assign body_off = cnt_q - 7'd6;
  assign sum_add  = sum_q + {8'h00, b};

  assign rx_i.ready             = in_ready;
  assign frame_o.valid          = out_valid_q;
  assign frame_o.frame_class    = out_class_q;
  assign frame_o.frame_command  = out_cmd_q;
  assign frame_o.payload_length = out_len_q;
  assign frame_o.byte_position  = out_pos_q;
  assign frame_o.payload_byte   = out_byte_q;
  assign frame_o.has_payload    = out_has_q;
  assign frame_o.last           = out_last_q;

  fds16_store u_store (
    .clk_i     (clk_i),
    .wr_i      (st_wr),
    .rd_i      (st_rd),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q  <= OWN_ADDR_RESET;
      peer_addr_q <= PEER_ADDR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OWN_ADDR:  own_addr_q  <= cfg_data_i;
        REG_PEER_ADDR: peer_addr_q <= cfg_data_i;
      endcase
    end
  end

  always_comb begin
    ctl_d       = ctl_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    class_d     = class_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    sum_d       = sum_q;
    tok_d       = tok_q;
    sum_lo_d    = sum_lo_q;
    rd_idx_d    = rd_idx_q;
    out_load    = 1'b0;
    out_class_d = out_class_q;
    out_cmd_d   = out_cmd_q;
    out_len_d   = out_len_q;
    out_pos_d   = out_pos_q;
    out_byte_d  = out_byte_q;
    out_has_d   = out_has_q;
    out_last_d  = out_last_q;
    st_wr.en    = 1'b0;
    st_wr.addr  = body_off[IdxW-1:0];
    st_wr.data  = b;
    st_rd.en    = 1'b0;
    st_rd.addr  = rd_idx_q;

    unique case (ctl_q)
      CTL_PARSE: begin
        if (in_acc) begin
          unique case (phase_q)
            PH_HEAD: begin
              sum_d = sum_add;
              if (cnt_q == 7'd1 && b != own_addr_q) tok_d = 1'b0;
              if (cnt_q == 7'd2 && b != peer_addr_q) tok_d = 1'b0;
              if (cnt_q == 7'd3) class_d = b;
              if (cnt_q == 7'd4) cmd_d = b;
              if (cnt_q >= 7'd5) begin
                if (!tok_q || b > 8'(MaxPayload)) begin
                  // a head byte in the length slot of a bad frame (bad address or length) opens a new frame
                  if (b == HEAD_BYTE) begin
                    phase_d = PH_HEAD;
                    cnt_d   = 7'd1;
                    sum_d   = {8'h00, HEAD_BYTE};
                    tok_d   = 1'b1;
                  end else begin
                    phase_d = PH_HUNT;
                    cnt_d   = 7'd0;
                    tok_d   = 1'b0;
                  end
                end else begin
                  len_d   = b[5:0];
                  cnt_d   = 7'd6;
                  tok_d   = 1'b0;
                  phase_d = PH_BODY;
                end
              end else begin
                cnt_d = cnt_q + 7'd1;
              end
            end
            PH_BODY: begin
              if (body_off < {1'b0, len_q}) begin
                st_wr.en = 1'b1;
                sum_d    = sum_add;
                cnt_d    = cnt_q + 7'd1;
              end else if (body_off == {1'b0, len_q}) begin
                tok_d = (b == TAIL_BYTE);
                sum_d = sum_add;
                cnt_d = cnt_q + 7'd1;
              end else if (body_off == {1'b0, len_q} + 7'd1) begin
                sum_lo_d = b;
                cnt_d    = cnt_q + 7'd1;
              end else begin
                if (tok_q && {b, sum_lo_q} == sum_q) begin
                  if (len_q == 6'd0) begin
                    out_load    = 1'b1;
                    out_class_d = class_q;
                    out_cmd_d   = cmd_q;
                    out_len_d   = len_q;
                    out_pos_d   = 6'd0;
                    out_byte_d  = 8'h00;
                    out_has_d   = 1'b0;
                    out_last_d  = 1'b1;
                  end else begin
                    ctl_d    = CTL_RD;
                    rd_idx_d = '0;
                  end
                end
                phase_d = PH_HUNT;
                cnt_d   = 7'd0;
                tok_d   = 1'b0;
              end
            end
            default: begin
              if (b == HEAD_BYTE) begin
                phase_d = PH_HEAD;
                cnt_d   = 7'd1;
                sum_d   = {8'h00, HEAD_BYTE};
                tok_d   = 1'b1;
              end else begin
                phase_d = PH_HUNT;
                cnt_d   = 7'd0;
              end
            end
          endcase
        end
      end
      CTL_RD: begin
        st_rd.en = 1'b1;
        ctl_d    = CTL_LD;
      end
      CTL_LD: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_class_d = class_q;
          out_cmd_d   = cmd_q;
          out_len_d   = len_q;
          out_pos_d   = 6'(rd_idx_q);
          out_byte_d  = rd_data;
          out_has_d   = 1'b1;
          out_last_d  = (6'(rd_idx_q) + 6'd1 == len_q);
          rd_idx_d    = rd_idx_q + IdxW'(1);
          ctl_d       = out_last_d ? CTL_PARSE : CTL_RD;
        end
      end
      default: ctl_d = CTL_PARSE;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (frame_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= CTL_PARSE;
      phase_q     <= PH_HUNT;
      cnt_q       <= 7'd0;
      class_q     <= 8'h00;
      cmd_q       <= 8'h00;
      len_q       <= 6'd0;
      sum_q       <= 16'h0000;
      tok_q       <= 1'b0;
      sum_lo_q    <= 8'h00;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ctl_q       <= ctl_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      class_q     <= class_d;
      cmd_q       <= cmd_d;
      len_q       <= len_d;
      sum_q       <= sum_d;
      tok_q       <= tok_d;
      sum_lo_q    <= sum_lo_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_class_q <= out_class_d;
    out_cmd_q   <= out_cmd_d;
    out_len_q   <= out_len_d;
    out_pos_q   <= out_pos_d;
    out_byte_q  <= out_byte_d;
    out_has_q   <= out_has_d;
    out_last_q  <= out_last_d;
  end

  `FDS16_ASSERT_IMP(a_no_rx_in_readback, ctl_q != CTL_PARSE, !rx_i.ready)
  `FDS16_ASSERT_IMP(a_no_overwrite, out_load, !out_valid_q || frame_o.ready)
  `FDS16_ASSERT_NEXT(a_read_then_load, ctl_q == CTL_RD, ctl_q == CTL_LD)
  `FDS16_ASSERT_IMP(a_last_pos, out_valid_q && out_has_q && out_last_q,
                    out_pos_q + 6'd1 == out_len_q)
  `FDS16_ASSERT_IMP(a_body_count, phase_q == PH_BODY, cnt_q >= 7'd6)

endmodule

`default_nettype wire
